[hdl/urpig_pkg.sv]
package urpig_pkg;

    // Map size is 2**PIXEL_BITS pixels
    localparam int PIXEL_BITS = 20;

    localparam int GEN_W      = 64;
    localparam int COUNT_W    = 21;
    localparam int IDX_W      = 20;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam int CNT_W  = PIXEL_BITS + 1;
    localparam int REM_W  = PIXEL_BITS + 2;
    localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // Visited map: rows of ROW_W bits, one row per RAM word
    localparam int COL_BITS = (PIXEL_BITS >= 10) ? 5 : 2;
    localparam int ROW_BITS = PIXEL_BITS - COL_BITS;
    localparam int ROW_W    = 1 << COL_BITS;
    localparam int MAP_ROWS = 1 << ROW_BITS;

    localparam int DIV_CNT_W = $clog2(GEN_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(GEN_W - 1);

    localparam int SH_A = 21;
    localparam int SH_B = 35;
    localparam int SH_C = 4;

    localparam logic [GEN_W-1:0]   SEED_RESET        = GEN_W'(1);
    localparam logic [COUNT_W-1:0] PIXEL_COUNT_RESET = COUNT_W'(1048576);
    localparam logic [WIDE_W-1:0]  MAP_SIZE          = WIDE_W'(1) << PIXEL_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_SEED        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = CFG_IDX_W'(1);

    typedef struct packed {
        logic accept;
        logic exh;
        logic step;
        logic div;
        logic look;
        logic mark;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_busy;
        logic exh_cond;
        logic div_last;
        logic hit;
        logic out_free;
    } t_stat;

    function automatic logic [GEN_W-1:0] xorshift(input logic [GEN_W-1:0] s);
        logic [GEN_W-1:0] t;
        t = s ^ (s << SH_A);
        t = t ^ (t >> SH_B);
        t = t ^ (t << SH_C);
        return t;
    endfunction

    // Saturate a programmed pixel count to the map size
    function automatic logic [CNT_W-1:0] eff_count(input logic [COUNT_W-1:0] pc);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(pc);
        if (w > MAP_SIZE) begin
            w = MAP_SIZE;
        end
        return CNT_W'(w);
    endfunction

endpackage

[hdl/urpig_in_if.sv]
interface urpig_in_if;
    import urpig_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              restart;
    logic              last_byte;

    modport source (output valid, data_byte, restart, last_byte, input ready);
    modport sink   (input valid, data_byte, restart, last_byte, output ready);
endinterface

[hdl/urpig_out_if.sv]
interface urpig_out_if;
    import urpig_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  pixel_index;
    logic [BYTE_W-1:0] alpha_value;
    logic              exhausted;
    logic              last_index;

    modport source (output valid, pixel_index, alpha_value, exhausted, last_index,
                    input ready);
    modport sink   (input valid, pixel_index, alpha_value, exhausted, last_index,
                    output ready);
endinterface

[hdl/unique_random_pixel_index_generator.sv]
// Each draw is an xorshift step, a bit-serial modulo, a map read and a test; a draw that
//   hits a pixel already used is redrawn. An exhausted word skips the draw loop, and a
//   restart word first waits out the clear pass of the visited map.
// One word in flight: input ready stays low until its result is emitted.
// Reset (synchronous, active low): seed 1, pixel count 2**20, then a clear pass over the
//   2**15 rows of the visited map, one 32-bit row per cycle, with input ready low.
//   A restart word or a pixel_count write starts the same clear pass.
module unique_random_pixel_index_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    urpig_in_if.sink                        i_in,
    urpig_out_if.source                     o_out,
    input  logic                            i_cfg_we,
    input  logic [urpig_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urpig_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import urpig_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Controller: sequences accept, exhaustion check, draw loop and result hand-off.
    urpig_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath: config registers, generator, serial divider, visited map,
    // used count and the output register that decouples the result side.
    urpig_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (i_in.data_byte),
        .i_restart     (i_in.restart),
        .i_last_byte   (i_in.last_byte),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_pixel_index (o_out.pixel_index),
        .o_alpha_value (o_out.alpha_value),
        .o_exhausted   (o_out.exhausted),
        .o_last_index  (o_out.last_index)
    );
endmodule

[hdl/urpig_ram.sv]
module urpig_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/urpig_ctrl.sv]
module urpig_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  urpig_pkg::t_stat i_stat,
    output urpig_pkg::t_cmd  o_cmd
);
    import urpig_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_STEP   = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_LOOK   = 7'b0010000,
        S_TEST   = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !i_stat.clr_busy;
                if (i_in_valid && !i_stat.clr_busy) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                // wait out a map clear started by a restart or a pixel_count write
                if (!i_stat.clr_busy) begin
                    if (i_stat.exh_cond) begin
                        o_cmd.exh = 1'b1;
                        n_state   = S_FINISH;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_TEST;
            end
            S_TEST: begin
                if (i_stat.hit) begin
                    n_state = S_STEP;
                end else begin
                    o_cmd.mark = 1'b1;
                    n_state    = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

[hdl/urpig_dp.sv]
module urpig_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  urpig_pkg::t_cmd                 i_cmd,
    output urpig_pkg::t_stat                o_stat,
    input  logic                            i_cfg_we,
    input  logic [urpig_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urpig_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [urpig_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                            i_restart,
    input  logic                            i_last_byte,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [urpig_pkg::IDX_W-1:0]      o_pixel_index,
    output logic [urpig_pkg::BYTE_W-1:0]     o_alpha_value,
    output logic                            o_exhausted,
    output logic                            o_last_index
);
    import urpig_pkg::*;

    logic [GEN_W-1:0]     r_seed;
    logic [CNT_W-1:0]     r_cnt;
    logic [GEN_W-1:0]     r_gen;
    logic [CNT_W-1:0]     r_used;
    logic                 r_clr_busy;
    logic [ROW_BITS-1:0]  r_clr_row;
    logic [GEN_W-1:0]     r_div;
    logic [REM_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [BYTE_W-1:0]    r_byte;
    logic                 r_last;
    logic                 r_exh;
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_idx;
    logic [BYTE_W-1:0]    r_out_alpha;
    logic                 r_out_exh;
    logic                 r_out_last;

    logic [REM_W-1:0]      w_trial;
    logic [REM_W-1:0]      n_rem;
    logic [GEN_W-1:0]      w_next_gen;
    logic [PIXEL_BITS-1:0] w_idx;
    logic [ROW_BITS-1:0]   w_row;
    logic [COL_BITS-1:0]   w_col;
    logic [ROW_W-1:0]      w_rdata;
    logic                  w_we;
    logic [ROW_BITS-1:0]   w_waddr;
    logic [ROW_W-1:0]      w_wdata;
    logic                  w_cfg_cnt;

    // one restoring division step: shift in the next dividend bit
    assign w_trial    = {r_rem[REM_W-2:0], r_div[GEN_W-1]};
    assign n_rem      = (w_trial >= REM_W'(r_cnt)) ? (w_trial - REM_W'(r_cnt)) : w_trial;
    assign w_next_gen = xorshift(r_gen);

    assign w_idx = r_rem[PIXEL_BITS-1:0];
    assign w_row = w_idx[PIXEL_BITS-1:COL_BITS];
    assign w_col = w_idx[COL_BITS-1:0];

    // clear sweep owns the write port while it runs
    assign w_we    = r_clr_busy || i_cmd.mark;
    assign w_waddr = r_clr_busy ? r_clr_row : w_row;
    assign w_wdata = r_clr_busy ? '0 : (w_rdata | (ROW_W'(1) << w_col));

    assign w_cfg_cnt = i_cfg_we && (i_cfg_idx == REG_PIXEL_COUNT);

    urpig_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAP_ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.look),
        .i_raddr (w_row),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= SEED_RESET;
            r_cnt       <= eff_count(PIXEL_COUNT_RESET);
            r_gen       <= SEED_RESET;
            r_used      <= '0;
            r_clr_busy  <= 1'b1;
            r_clr_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (&r_clr_row) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (i_cfg_we && (i_cfg_idx == REG_SEED)) begin
                r_seed <= i_cfg_data;
            end
            if (w_cfg_cnt) begin
                r_cnt      <= eff_count(i_cfg_data[COUNT_W-1:0]);
                r_used     <= '0;
                r_clr_busy <= 1'b1;
                r_clr_row  <= '0;
            end

            if (i_cmd.accept && i_restart) begin
                r_gen      <= r_seed;
                r_used     <= '0;
                r_clr_busy <= 1'b1;
                r_clr_row  <= '0;
            end else if (i_cmd.step) begin
                r_gen <= w_next_gen;
            end

            if (i_cmd.mark) begin
                r_used <= r_used + 1'b1;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
        if (i_cmd.step) begin
            r_div     <= w_next_gen;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div) begin
            r_div     <= r_div << 1;
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.exh) begin
            r_exh <= 1'b1;
        end else if (i_cmd.mark) begin
            r_exh <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_idx   <= r_exh ? '0 : IDX_W'(w_idx);
            r_out_alpha <= r_byte;
            r_out_exh   <= r_exh;
            r_out_last  <= r_last;
        end
    end

    assign o_stat.clr_busy = r_clr_busy;
    assign o_stat.exh_cond = (r_cnt == '0) || (r_used >= r_cnt) || (r_gen == '0);
    assign o_stat.div_last = (r_div_cnt == DIV_LAST);
    assign o_stat.hit      = w_rdata[w_col];
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_out_idx;
    assign o_alpha_value = r_out_alpha;
    assign o_exhausted   = r_out_exh;
    assign o_last_index  = r_out_last;
endmodule

[hdl/urpig_checker.sv]
module urpig_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [urpig_pkg::IDX_W-1:0]  i_pixel_index,
    input logic [urpig_pkg::BYTE_W-1:0] i_alpha_value,
    input logic                        i_exhausted,
    input logic                        i_last_index
);
    import urpig_pkg::*;

    // exhausted result carries index zero
    a_exh_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_exhausted) |-> (i_pixel_index == '0))
        else $error("exhausted word with nonzero pixel_index");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_pixel_index) &&
            $stable(i_alpha_value) && $stable(i_exhausted) && $stable(i_last_index)))
        else $error("stalled output word changed");

    // one word in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted while a word is in progress");

    // reset drops output valid and blocks input for the clear pass
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && !i_in_ready))
        else $error("ports active right after reset");
endmodule

bind unique_random_pixel_index_generator urpig_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_pixel_index (o_out.pixel_index),
    .i_alpha_value (o_out.alpha_value),
    .i_exhausted   (o_out.exhausted),
    .i_last_index  (o_out.last_index)
);
